// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file ssr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/ssr_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package ssr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REPLACE_BYTES  = 2'd2,
    CFG_REPLACE_LENGTH = 2'd3
  } cfg_index_t;

  // Where an emitted result takes its byte from.
  typedef enum logic [1:0] {
    SRC_WINDOW,
    SRC_REPLACE,
    SRC_NONE
  } src_t;

  typedef struct packed {
    logic accept;  // store the incoming byte in the window
    logic decide;  // apply match result (clear window, bump count)
    logic emit;    // load the output register
    src_t src;
    logic last;    // last result of this request
  } ssr_cmd_t;

  typedef struct packed {
    logic             is_match;
    logic [LEN_W-1:0] total;     // results this request produces
    logic             fin;
    logic             out_free;
  } ssr_status_t;

endpackage

// ----- rtl/ssr_ctrl.sv -----
// Sequencer: accepts a request, plans its results and paces their emission.
module ssr_ctrl import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ssr_status_t status,
  output ssr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] remaining;
  src_t             src;

  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = (state == S_IDLE) && in_valid;
  assign cmd.decide = (state == S_DECIDE);
  assign cmd.emit   = (state == S_EMIT) && status.out_free;
  assign cmd.src    = src;
  assign cmd.last   = (remaining == LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      src       <= SRC_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (status.total != '0) begin
            remaining <= status.total;
            src       <= status.is_match ? SRC_REPLACE : SRC_WINDOW;
            state     <= S_EMIT;
          end else if (status.fin) begin
            // nothing to send on a final request: one count-only result
            remaining <= LEN_W'(1);
            src       <= SRC_NONE;
            state     <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            remaining <= remaining - LEN_W'(1);
            if (remaining == LEN_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ssr_datapath.sv -----
// Window, configuration, matcher, replacement shifter, counter and output register.
module ssr_datapath import ssr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  is_final,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  byte_valid,
  output logic                  run_last,
  output logic                  text_done,
  output logic [CNT_W-1:0]      replace_count,
  input  ssr_cmd_t              cmd,
  output ssr_status_t           status
);

  logic [PATTERN_MAX*BYTE_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]              pattern_length;
  logic [REPLACE_MAX*BYTE_W-1:0] replace_bytes;
  logic [LEN_W-1:0]              replace_length;

  logic [BYTE_W-1:0]             window [PATTERN_MAX];
  logic [LEN_W-1:0]              fill;
  logic                          fin;
  logic [REPLACE_MAX*BYTE_W-1:0] rep_sh;
  logic [CNT_W-1:0]              match_total;

  logic [LEN_W-1:0]              plen;
  logic [LEN_W-1:0]              rlen;
  logic [PATTERN_MAX-1:0]        byte_ok;
  logic                          is_match;
  logic [LEN_W-1:0]              pops;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
      replace_bytes  <= '0;
      replace_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_REPLACE_BYTES:  replace_bytes  <= cfg_data;
        CFG_REPLACE_LENGTH: replace_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign plen = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;
  assign rlen = (replace_length > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : replace_length;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      byte_ok[i] = (window[i] == pattern_bytes[i*BYTE_W +: BYTE_W]) || (LEN_W'(i) >= plen);
    end
  end

  assign is_match = (plen != '0) && (fill == plen) && (&byte_ok);

  always_comb begin
    if (fin || plen == '0) begin
      pops = fill;
    end else if (fill > plen) begin
      pops = fill - plen + LEN_W'(1);
    end else if (fill == plen) begin
      pops = LEN_W'(1);
    end else begin
      pops = '0;
    end
  end

  assign status.is_match = is_match;
  assign status.total    = is_match ? rlen : pops;
  assign status.fin      = fin;
  assign status.out_free = !out_valid || out_ready;

  // window storage: written at the fill position, shifted toward the head on a pop
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      window[fill[WIN_IDX_W-1:0]] <= text_byte;
    end else if (cmd.emit && cmd.src == SRC_WINDOW) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        window[i] <= window[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) fin <= is_final;
    if (cmd.decide) rep_sh <= replace_bytes;
    else if (cmd.emit && cmd.src == SRC_REPLACE) rep_sh <= rep_sh >> BYTE_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      match_total <= '0;
    end else begin
      if (cmd.accept) begin
        fill <= fill + LEN_W'(1);
      end else if (cmd.decide && is_match) begin
        fill <= '0;
        if (match_total != '1) match_total <= match_total + CNT_W'(1);
      end else if (cmd.emit) begin
        if (cmd.src == SRC_WINDOW) fill <= fill - LEN_W'(1);
        // restart the count once the final result of the text leaves
        if (cmd.last && fin) match_total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.src)
        SRC_WINDOW: begin
          out_byte   <= window[0];
          byte_valid <= 1'b1;
        end
        SRC_REPLACE: begin
          out_byte   <= rep_sh[BYTE_W-1:0];
          byte_valid <= 1'b1;
        end
        default: begin
          out_byte   <= '0;
          byte_valid <= 1'b0;
        end
      endcase
      run_last      <= cmd.last;
      text_done     <= cmd.last && fin;
      replace_count <= match_total;
    end
  end

endmodule

// ----- rtl/stream_search_replace.sv -----
// Top level of the streaming search-and-replace block.
// Text enters one byte per request on in_valid/in_ready (text_byte, is_final)
// and leaves as results on out_valid/out_ready. Each result carries a byte
// (byte_valid 1) or is count-only, plus run_last on the last result of a
// request, text_done on the last result of the text, and the saturating
// replacement count. Pattern and replacement are set via cfg_write/cfg_index/
// cfg_data; the user must write them only while the block is idle, unchecked.
// Timing: a request is taken in the idle state, planned in the next cycle,
// and its n results (0 to 8) are loaded into the output register one per
// cycle while the receiver keeps up; the next request is taken only after
// the last result of this one is loaded. The sequencer in ssr_ctrl handles
// one request at a time.
// When the receiver stalls, the held result stays in the output register
// and emission pauses; the next request is taken as soon as the sequencer
// is idle, even while the final result of the last one still waits.
// Reset clears configuration, window fill, count and the output valid flag.
module stream_search_replace import ssr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  is_final,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  byte_valid,
  output logic                  run_last,
  output logic                  text_done,
  output logic [CNT_W-1:0]      replace_count
);

  ssr_cmd_t    cmd;
  ssr_status_t status;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .text_byte     (text_byte),
    .is_final      (is_final),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .text_done     (text_done),
    .replace_count (replace_count),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// ----- rtl/ssr_checker.sv -----
// Port-level checker for the search-and-replace block, bound to the top level.
`include "assert_macros.svh"
module ssr_checker import ssr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [BYTE_W-1:0]     out_byte,
  input logic                  byte_valid,
  input logic                  run_last,
  input logic                  text_done,
  input logic [CNT_W-1:0]      replace_count
);

  // a stalled result holds its payload
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))
  `ASSERT_NXT(a_count_hold, clk, rst, out_valid && !out_ready, $stable(replace_count))

  // a count-only result is the sole and final result of a final request
  `ASSERT_IMP(a_count_only, clk, rst, out_valid && !byte_valid, out_byte == '0 && run_last && text_done)

  `ASSERT_IMP(a_done_last, clk, rst, out_valid && text_done, run_last)

  // no new request while results of the current one are still to come
  `ASSERT_IMP(a_no_overlap, clk, rst, out_valid && !run_last, !in_ready)

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (.*);

// ----- dv/tb_stream_search_replace.sv -----
// Testbench for stream_search_replace: directed and random texts against a predictor.
`timescale 1ns / 1ps

module tb_stream_search_replace;
  import ssr_pkg::*;

  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        text_done;
    logic [15:0] replace_count;
  } text_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  cfg_index_t            cfg_index = CFG_PATTERN_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     text_byte = '0;
  logic                  is_final = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  byte_valid;
  logic                  run_last;
  logic                  text_done;
  logic [CNT_W-1:0]      replace_count;

  stream_search_replace dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte), .is_final(is_final),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_valid(byte_valid), .run_last(run_last), .text_done(text_done),
    .replace_count(replace_count)
  );

  always #5 clk = ~clk;

  // Shadow of the block's registers and state
  logic [63:0]  pat_reg = '0;
  logic [3:0]   plen_reg = '0;
  logic [63:0]  rep_reg = '0;
  logic [3:0]   rlen_reg = '0;
  logic [7:0]   win_bytes [8] = '{default: 8'h00};
  int           win_fill = 0;
  logic [15:0]  match_total = '0;

  text_result_t run_q[$];
  text_result_t replaced_text_q[$];
  text_result_t want;

  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int replacements_made = 0;
  int texts_closed = 0;

  always @(negedge clk) begin
    out_ready <= stall_on ? ($urandom_range(99) >= 7) : 1'b1;
  end

  function automatic void shift_out_oldest();
    int i;
    run_q.push_back('{out_byte: win_bytes[0], byte_valid: 1'b1, run_last: 1'b0,
                      text_done: 1'b0, replace_count: '0});
    for (i = 0; i < 7; i++) win_bytes[i] = win_bytes[i+1];
    win_fill--;
  endfunction

  // Work out the results of one accepted request and queue them.
  function automatic void predict_replace(input logic [7:0] b, input logic fin);
    int plen, rlen, i, k;
    logic hit;
    plen = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : plen_reg;
    rlen = (rlen_reg > REPLACE_MAX) ? REPLACE_MAX : rlen_reg;
    run_q.delete();
    win_bytes[win_fill] = b;
    win_fill++;
    if (plen == 0) begin
      while (win_fill > 0) shift_out_oldest();
    end else if (win_fill > plen) begin
      // pattern got shorter while bytes waited: drain without testing a match
      while (win_fill > plen - 1) shift_out_oldest();
    end else if (win_fill == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (win_bytes[i] != pat_reg[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++)
          run_q.push_back('{out_byte: rep_reg[8*i +: 8], byte_valid: 1'b1, run_last: 1'b0,
                            text_done: 1'b0, replace_count: '0});
        if (match_total != 16'hFFFF) match_total++;
        replacements_made++;
        win_fill = 0;
      end else begin
        shift_out_oldest();
      end
    end
    if (fin) begin
      while (win_fill > 0) shift_out_oldest();
      if (run_q.size() == 0) run_q.push_back('0);
    end
    for (k = 0; k < run_q.size(); k++) begin
      run_q[k].run_last = (k == run_q.size() - 1);
      run_q[k].text_done = fin && (k == run_q.size() - 1);
      run_q[k].replace_count = match_total;
      replaced_text_q.push_back(run_q[k]);
    end
    if (fin) begin
      match_total = '0;
      texts_closed++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (replaced_text_q.size() == 0) begin
        $error("result with none pending: out_byte %0h byte_valid %0b", out_byte, byte_valid);
        mismatch_count++;
      end else begin
        want = replaced_text_q.pop_front();
        check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
        check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
        check_field("run_last", 16'(want.run_last), 16'(run_last));
        check_field("text_done", 16'(want.text_done), 16'(text_done));
        check_field("replace_count", want.replace_count, replace_count);
      end
      results_checked++;
    end
  end

  // Drop valid, wait for every pending result, then let the sequencer settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replaced_text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] b, input logic fin);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    is_final <= fin;
    do @(posedge clk); while (!in_ready);
    predict_replace(b, fin);
    requests_sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_PATTERN_BYTES:  pat_reg = val;
      CFG_PATTERN_LENGTH: plen_reg = val[3:0];
      CFG_REPLACE_BYTES:  rep_reg = val;
      CFG_REPLACE_LENGTH: rlen_reg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [63:0] pat, input logic [3:0] plen,
                          input logic [63:0] rep, input logic [3:0] rlen);
    wait_idle();
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, {60'b0, plen});
    write_reg(CFG_REPLACE_BYTES, rep);
    write_reg(CFG_REPLACE_LENGTH, {60'b0, rlen});
  endtask

  // Mostly bytes of the current pattern, so partial matches show up often.
  function automatic logic [7:0] text_pick();
    if ($urandom_range(99) < 75) return pat_reg[8*$urandom_range(7, 0) +: 8];
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic test_pass_through();
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'hA5, 1'b1);
  endtask

  // "aab": mismatch on the first pair must not hide the match that follows
  task automatic test_match_after_partial();
    set_regs(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h63, 1'b1);
  endtask

  // Lengths above eight clamp; a full-width match yields eight bytes.
  task automatic test_full_length_clamped();
    int i;
    set_regs(64'h00FF_00FF_00FF_00FF, 4'd15, 64'hFF80_4020_1008_0400, 4'd9);
    for (i = 0; i < 8; i++) send_text(pat_reg[8*i +: 8], i == 7);
  endtask

  task automatic test_delete_to_empty();
    set_regs(64'h71, 4'd1, 64'h0, 4'd0);
    send_text(8'h71, 1'b1);
  endtask

  // Shorten the pattern with three bytes waiting; "cd" must not match then.
  task automatic test_pattern_shortened();
    set_regs(64'h7A797877, 4'd4, 64'h21, 4'd1);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h63, 1'b0);
    set_regs(64'h6463, 4'd2, 64'h21, 4'd1);
    send_text(8'h64, 1'b1);
  endtask

  task automatic test_random_texts();
    int phase, sent, phase_items, n, eff_plen, i;
    logic [3:0] plen, rlen;
    logic [7:0] chunk_q[$];
    phase = 0;
    sent = 0;
    while (sent < 420) begin
      case (phase)
        0: begin plen = 4'd8; rlen = 4'd8; end
        1: begin plen = 4'd1; rlen = 4'd0; end
        2: begin plen = 4'd0; rlen = 4'($urandom_range(15, 0)); end
        default: begin
          plen = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9))
                                           : 4'($urandom_range(8, 1));
          rlen = 4'($urandom_range(15, 0));
        end
      endcase
      // long stretch with neither side idling
      gaps_on = (phase != 3);
      stall_on = (phase != 3);
      set_regs({$urandom, $urandom}, plen, {$urandom, $urandom}, rlen);
      // narrow the alphabet of the pattern so texts hit it
      for (i = 1; i < 8; i++)
        if ($urandom_range(99) < 50) pat_reg[8*i +: 8] = pat_reg[8*$urandom_range(i-1, 0) +: 8];
      write_reg(CFG_PATTERN_BYTES, pat_reg);
      eff_plen = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : plen_reg;
      chunk_q.delete();
      phase_items = $urandom_range(55, 25);
      for (n = 0; n < phase_items; n++) begin
        if (chunk_q.size() == 0) begin
          if (eff_plen > 0 && $urandom_range(99) < 60) begin
            for (i = 0; i < eff_plen; i++) chunk_q.push_back(pat_reg[8*i +: 8]);
            if ($urandom_range(99) < 15) chunk_q[$urandom_range(eff_plen - 1, 0)] = text_pick();
            if ($urandom_range(99) < 10) chunk_q = chunk_q[0:$urandom_range(eff_plen - 1, 0)];
          end else begin
            repeat ($urandom_range(3, 1)) chunk_q.push_back(text_pick());
          end
        end
        if (phase == 4 && n == phase_items / 2) wait_idle();
        send_text(chunk_q.pop_front(), $urandom_range(99) < 6);
        sent++;
      end
      // leave the text open sometimes so the next setting meets waiting bytes
      if ($urandom_range(99) < 60) begin
        send_text(text_pick(), 1'b1);
        sent++;
      end
      phase++;
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
    send_text(text_pick(), 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_pass_through();
    test_match_after_partial();
    test_full_length_clamped();
    test_delete_to_empty();
    test_pattern_shortened();
    test_random_texts();
    wait_idle();
    $display("%0d text bytes in %0d texts, %0d results checked, %0d replacements",
             requests_sent, texts_closed, results_checked, replacements_made);
    $display("settings covered: pass-through, deletion, clamped lengths, full-width match,");
    $display("shortened pattern with waiting bytes, stalls and gap-free streaming");
    if (mismatch_count == 0) begin
      $display("tb_stream_search_replace passed");
    end else begin
      $display("tb_stream_search_replace failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_stream_search_replace failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ssr_pkg.sv
rtl/ssr_ctrl.sv
rtl/ssr_datapath.sv
rtl/stream_search_replace.sv
rtl/ssr_checker.sv
dv/tb_stream_search_replace.sv
